/* design/assert_macros.svh */
// Assertion shorthands shared by the lease handle table modules.
// Both expect clk and arst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define LHT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define LHT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* design/lht_pkg.sv */
package lht_pkg;

	localparam int SLOTS     = 64;
	localparam int TIME_BITS = 48;
	localparam int TB1       = TIME_BITS + 1;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int GRP_SIZE  = 8;
	localparam int GRP_N     = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_IDX_W = (GRP_SIZE > 1) ? $clog2(GRP_SIZE) : 1;
	localparam int HALF      = 16;

	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	typedef enum logic [2:0] {
		ACT_ALLOC, ACT_LOOKUP, ACT_FREE, ACT_LOCK,
		ACT_TIMEOUT, ACT_REPORT, ACT_RELEASES, ACT_TICK
	} act_t;

	typedef enum logic [2:0] {
		ST_OK, ST_RANGE, ST_GEN, ST_UNALLOC, ST_FULL
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_CHK, BK_GRP, BK_PICK, BK_TRD, BK_TCHK, BK_TEND, BK_EMIT
	} back_state_t;

	typedef struct packed {
		act_t              act;
		logic              oor;
		logic [SLOT_W-1:0] slot;
		logic [HALF-1:0]   gen;
		logic [31:0]       bsize;
		logic [31:0]       lease;
		logic              flag;
		logic [7:0]        extra;
	} cmd_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] expiry;
		logic [HALF-1:0]      gen;
		logic [7:0]           rel;
		logic [31:0]          size;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] handle;
		logic [31:0] size;
		logic        timed_out;
		logic        report;
		logic        last;
	} result_t;

	function automatic logic [31:0] make_handle(logic [HALF-1:0] gen, logic [SLOT_W-1:0] slot);
		logic [HALF-1:0] low;
		low = HALF'(slot) + HALF'(1);
		return {gen, low};
	endfunction

	function automatic logic [TIME_BITS-1:0] expiry_from(logic [TIME_BITS-1:0] now,
		logic [31:0] lease);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, now} + TB1'(lease);
		if (lease == 32'd0) begin
			return '0;
		end
		if (sum[TIME_BITS]) begin
			return TIME_MAX;
		end
		return sum[TIME_BITS-1:0];
	endfunction

endpackage

/* design/lease_handle_table_unit.sv */
// Lease handle table: a table of lease slots addressed by handles of the form
// generation<<16 | slot+1. Each transaction on the input carries one command.
// Alloc, lookup, free, set lock, set timeout, set report flag and set release
// count each give exactly one result transaction with last set. A tick advances
// the millisecond clock by one and gives one result per slot that expired, in
// ascending slot order with last on the final one, or a single all-zero result
// with last set when nothing expired. A command is accepted into a two-entry
// queue, so up to two commands can wait while the back end works. A handle
// command with an out-of-range slot part skips the slot read; an alloc runs a
// two-stage free-slot search whose second stage also writes the slot; a tick
// scans the slot memory one entry at a time through its single read port. The
// result register may wait on out_ready, and that holds the back end. No
// clearing pass is needed after reset: the per-slot in-use bits reset at once
// and gate every read of the slot memory.
module lease_handle_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [31:0] handle,
	input  logic [31:0] buffer_size,
	input  logic [31:0] lease_ms,
	input  logic        flag,
	input  logic [7:0]  extra_releases,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] result_handle,
	output logic [31:0] result_size,
	output logic        timed_out,
	output logic        report_error,
	output logic        last
);

	lht_pkg::cmd_t    f_cmd;
	lht_pkg::cmd_t    q_cmd;
	lht_pkg::result_t res;
	logic             push, q_full, q_valid, q_pop;

	// Front end: decodes the transaction and checks the slot range.
	lht_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.handle        (handle),
		.buffer_size   (buffer_size),
		.lease_ms      (lease_ms),
		.flag          (flag),
		.extra_releases(extra_releases),
		.q_full        (q_full),
		.push          (push),
		.cmd           (f_cmd)
	);

	// The queue lets the front keep accepting while the back end scans or stalls.
	lht_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (f_cmd),
		.pop   (q_pop),
		.valid (q_valid),
		.full  (q_full),
		.dout  (q_cmd)
	);

	// Back end: owns the slot state and the result register.
	lht_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_cmd),
		.q_pop    (q_pop),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_res  (res)
	);

	assign status        = res.status;
	assign result_handle = res.handle;
	assign result_size   = res.size;
	assign timed_out     = res.timed_out;
	assign report_error  = res.report;
	assign last          = res.last;

endmodule

/* design/lht_ram.sv */
module lht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/lht_front.sv */
module lht_front (
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    action,
	input  logic [31:0]   handle,
	input  logic [31:0]   buffer_size,
	input  logic [31:0]   lease_ms,
	input  logic          flag,
	input  logic [7:0]    extra_releases,
	input  logic          q_full,
	output logic          push,
	output lht_pkg::cmd_t cmd
);

	logic [lht_pkg::HALF-1:0] low;
	logic [lht_pkg::HALF-1:0] idx;

	assign low      = handle[lht_pkg::HALF-1:0];
	assign idx      = low - lht_pkg::HALF'(1);
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// A slot part of zero, or any slot part past the end of the table, is out of range.
	always_comb begin
		cmd.act   = lht_pkg::act_t'(action);
		cmd.oor   = (low == '0) || ({1'b0, low} > 17'(lht_pkg::SLOTS));
		cmd.slot  = idx[lht_pkg::SLOT_W-1:0];
		cmd.gen   = handle[31:lht_pkg::HALF];
		cmd.bsize = buffer_size;
		cmd.lease = lease_ms;
		cmd.flag  = flag;
		cmd.extra = extra_releases;
	end

endmodule

/* design/lht_queue.sv */
`include "assert_macros.svh"

module lht_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lht_pkg::cmd_t din,
	input  logic          pop,
	output logic          valid,
	output logic          full,
	output lht_pkg::cmd_t dout
);

	lht_pkg::cmd_t mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`LHT_NEVER(a_pop_empty, pop && (cnt_q == 2'd0), "queue popped while empty")
	`LHT_NEVER(a_cnt_range, cnt_q == 2'd3, "queue count beyond depth")
	`LHT_ASSERT(a_ptr_gap, (cnt_q == 2'd1) |-> (wp_q != rp_q), "queue pointers out of step")

endmodule

/* design/lht_back.sv */
`include "assert_macros.svh"

module lht_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  lht_pkg::cmd_t    q_data,
	output logic             q_pop,
	input  logic             out_ready,
	output logic             out_valid,
	output lht_pkg::result_t out_res
);

	localparam int EW = $bits(lht_pkg::entry_t);

	lht_pkg::back_state_t state_q, state_d;
	lht_pkg::cmd_t        cmd_q;
	lht_pkg::result_t     res_q, res_d, held_q, held_d, out_d;
	lht_pkg::entry_t      rd_entry, wr_entry;

	logic [lht_pkg::SLOTS-1:0] in_use_q, in_use_d;
	logic [lht_pkg::SLOTS-1:0] locked_q, locked_d;
	logic [lht_pkg::SLOTS-1:0] report_q, report_d;

	logic [lht_pkg::TIME_BITS-1:0] clock_q;
	logic [lht_pkg::HALF-1:0]      next_gen_q;
	logic [lht_pkg::SLOT_W-1:0]    idx_q, raddr, waddr, pick_slot;
	logic                          held_v_q, out_valid_q;
	logic [EW-1:0]                 ram_rdata;
	logic                          ram_we;

	logic [lht_pkg::GRP_N-1:0] grp_free_d, grp_free_q;
	logic [lht_pkg::GRP_IDX_W-1:0] grp_low_d [lht_pkg::GRP_N];
	logic [lht_pkg::GRP_IDX_W-1:0] grp_low_q [lht_pkg::GRP_N];

	logic cmd_ld, res_ld, out_ld, held_ld, tick_start, idx_inc, gen_inc, grp_ld;
	logic out_free, tick_hit, pick_found;
	lht_pkg::status_t chk_status;

	lht_ram #(.WIDTH(EW), .DEPTH(lht_pkg::SLOTS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wr_entry),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	assign rd_entry  = lht_pkg::entry_t'(ram_rdata);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	assign tick_hit = in_use_q[idx_q] && !locked_q[idx_q] && (rd_entry.expiry != '0) &&
		(clock_q >= rd_entry.expiry);

	always_comb begin
		if (!in_use_q[cmd_q.slot]) begin
			chk_status = lht_pkg::ST_UNALLOC;
		end else if (rd_entry.gen != cmd_q.gen) begin
			chk_status = lht_pkg::ST_GEN;
		end else begin
			chk_status = lht_pkg::ST_OK;
		end
	end

	// First stage of the free-slot search: one small priority encoder per group.
	always_comb begin
		for (int g = 0; g < lht_pkg::GRP_N; g++) begin
			grp_free_d[g] = 1'b0;
			grp_low_d[g]  = '0;
			for (int b = lht_pkg::GRP_SIZE - 1; b >= 0; b--) begin
				if ((g * lht_pkg::GRP_SIZE + b < lht_pkg::SLOTS) &&
					!in_use_q[(g * lht_pkg::GRP_SIZE + b) % lht_pkg::SLOTS]) begin
					grp_free_d[g] = 1'b1;
					grp_low_d[g]  = lht_pkg::GRP_IDX_W'(b);
				end
			end
		end
	end

	// Second stage: lowest group that has a free slot.
	always_comb begin
		pick_found = 1'b0;
		pick_slot  = '0;
		for (int g = lht_pkg::GRP_N - 1; g >= 0; g--) begin
			if (grp_free_q[g]) begin
				pick_found = 1'b1;
				pick_slot  = lht_pkg::SLOT_W'(g * lht_pkg::GRP_SIZE + int'(grp_low_q[g]));
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		cmd_ld     = 1'b0;
		res_ld     = 1'b0;
		res_d      = '0;
		out_ld     = 1'b0;
		out_d      = res_q;
		held_ld    = 1'b0;
		held_d     = '0;
		tick_start = 1'b0;
		idx_inc    = 1'b0;
		gen_inc    = 1'b0;
		grp_ld     = 1'b0;
		ram_we     = 1'b0;
		waddr      = cmd_q.slot;
		wr_entry   = rd_entry;
		raddr      = q_data.slot;
		in_use_d   = in_use_q;
		locked_d   = locked_q;
		report_d   = report_q;
		res_d.last = 1'b1;

		unique case (state_q)
			lht_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop  = 1'b1;
					cmd_ld = 1'b1;
					unique case (q_data.act)
						lht_pkg::ACT_TICK: begin
							tick_start = 1'b1;
							state_d    = lht_pkg::BK_TRD;
						end
						lht_pkg::ACT_ALLOC: begin
							state_d = lht_pkg::BK_GRP;
						end
						default: begin
							if (q_data.oor) begin
								res_d.status = lht_pkg::ST_RANGE;
								res_ld       = 1'b1;
								state_d      = lht_pkg::BK_EMIT;
							end else begin
								state_d = lht_pkg::BK_CHK;
							end
						end
					endcase
				end
			end
			lht_pkg::BK_CHK: begin
				res_d.status = chk_status;
				res_ld       = 1'b1;
				state_d      = lht_pkg::BK_EMIT;
				if (chk_status == lht_pkg::ST_OK) begin
					unique case (cmd_q.act)
						lht_pkg::ACT_LOOKUP: begin
							locked_d[cmd_q.slot] = cmd_q.flag;
							res_d.size           = rd_entry.size;
						end
						lht_pkg::ACT_FREE: begin
							if (rd_entry.rel != 8'd0) begin
								ram_we               = 1'b1;
								wr_entry.rel         = rd_entry.rel - 8'd1;
								locked_d[cmd_q.slot] = 1'b0;
							end else begin
								in_use_d[cmd_q.slot] = 1'b0;
								locked_d[cmd_q.slot] = 1'b0;
								report_d[cmd_q.slot] = 1'b0;
							end
						end
						lht_pkg::ACT_LOCK: begin
							locked_d[cmd_q.slot] = cmd_q.flag;
						end
						lht_pkg::ACT_TIMEOUT: begin
							ram_we          = 1'b1;
							wr_entry.expiry = lht_pkg::expiry_from(clock_q, cmd_q.lease);
						end
						lht_pkg::ACT_REPORT: begin
							report_d[cmd_q.slot] = cmd_q.flag;
						end
						lht_pkg::ACT_RELEASES: begin
							ram_we       = 1'b1;
							wr_entry.rel = cmd_q.extra;
						end
						default: begin
						end
					endcase
				end
			end
			lht_pkg::BK_GRP: begin
				grp_ld  = 1'b1;
				state_d = lht_pkg::BK_PICK;
			end
			lht_pkg::BK_PICK: begin
				res_ld  = 1'b1;
				state_d = lht_pkg::BK_EMIT;
				if (pick_found) begin
					ram_we              = 1'b1;
					waddr               = pick_slot;
					wr_entry.expiry     = lht_pkg::expiry_from(clock_q, cmd_q.lease);
					wr_entry.gen        = next_gen_q;
					wr_entry.rel        = 8'd0;
					wr_entry.size       = cmd_q.bsize;
					in_use_d[pick_slot] = 1'b1;
					locked_d[pick_slot] = 1'b0;
					report_d[pick_slot] = 1'b1;
					gen_inc             = 1'b1;
					res_d.handle        = lht_pkg::make_handle(next_gen_q, pick_slot);
				end else begin
					res_d.status = lht_pkg::ST_FULL;
				end
			end
			lht_pkg::BK_TRD: begin
				raddr   = idx_q;
				state_d = lht_pkg::BK_TCHK;
			end
			lht_pkg::BK_TCHK: begin
				raddr = idx_q;
				// An expired slot pushes the one held before it out with last clear.
				if (!(tick_hit && held_v_q && !out_free)) begin
					if (tick_hit) begin
						if (held_v_q) begin
							out_ld = 1'b1;
							out_d  = held_q;
						end
						held_ld           = 1'b1;
						held_d.status     = lht_pkg::ST_OK;
						held_d.handle     = lht_pkg::make_handle(rd_entry.gen, idx_q);
						held_d.timed_out  = 1'b1;
						held_d.report     = report_q[idx_q];
						held_d.last       = 1'b0;
						in_use_d[idx_q]   = 1'b0;
						locked_d[idx_q]   = 1'b0;
						report_d[idx_q]   = 1'b0;
					end
					idx_inc = 1'b1;
					if (idx_q == lht_pkg::SLOT_W'(lht_pkg::SLOTS - 1)) begin
						state_d = lht_pkg::BK_TEND;
					end else begin
						state_d = lht_pkg::BK_TRD;
					end
				end
			end
			lht_pkg::BK_TEND: begin
				res_ld = 1'b1;
				if (held_v_q) begin
					res_d      = held_q;
					res_d.last = 1'b1;
				end
				state_d = lht_pkg::BK_EMIT;
			end
			lht_pkg::BK_EMIT: begin
				if (out_free) begin
					out_ld  = 1'b1;
					out_d   = res_q;
					state_d = lht_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = lht_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lht_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q    <= '0;
			locked_q    <= '0;
			report_q    <= '0;
			clock_q     <= '0;
			next_gen_q  <= '0;
			idx_q       <= '0;
			held_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			in_use_q <= in_use_d;
			locked_q <= locked_d;
			report_q <= report_d;
			if (tick_start) begin
				if (clock_q != lht_pkg::TIME_MAX) begin
					clock_q <= clock_q + lht_pkg::TIME_BITS'(1);
				end
				idx_q    <= '0;
				held_v_q <= 1'b0;
			end else begin
				if (idx_inc) begin
					idx_q <= idx_q + lht_pkg::SLOT_W'(1);
				end
				if (held_ld) begin
					held_v_q <= 1'b1;
				end
			end
			if (gen_inc) begin
				next_gen_q <= next_gen_q + lht_pkg::HALF'(1);
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ld) begin
			cmd_q <= q_data;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (held_ld) begin
			held_q <= held_d;
		end
		if (out_ld) begin
			out_res <= out_d;
		end
		if (grp_ld) begin
			grp_free_q <= grp_free_d;
			grp_low_q  <= grp_low_d;
		end
	end

	`LHT_ASSERT(a_clock_mono, 1'b1 |=> (clock_q >= $past(clock_q)), "clock went backward")
	`LHT_NEVER(a_alloc_free, (state_q == lht_pkg::BK_PICK) && pick_found && in_use_q[pick_slot],
		"allocation picked a slot in use")
	`LHT_NEVER(a_timeout_ok, out_valid_q && out_res.timed_out && (out_res.status != lht_pkg::ST_OK),
		"expiry result with error status")

endmodule
